FILE: rtl/wto_pkg.sv
// Shared constants and types for the wavetable oscillator.
package wto_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int PHASE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int LEN_MIN_W  = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD      = 2'd0,
    MODE_TICK      = 2'd1,
    MODE_PHASE_CLR = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC = 1'd0,
    CFG_TABLE_LEN = 1'd1
  } cfg_reg_e;

endpackage

FILE: rtl/wto_in_if.sv
// Input channel of the wavetable oscillator: load, tick and phase-clear words.
interface wto_in_if #(
  parameter int IDX_W = 10,
  parameter int SMP_W = 16
);
  logic                          valid;
  logic                          ready;
  logic [wto_pkg::MODE_W-1:0]    mode;
  logic [IDX_W-1:0]              entry_index;
  logic signed [SMP_W-1:0]       entry_value;

  modport source (output valid, mode, entry_index, entry_value, input ready);
  modport sink   (input valid, mode, entry_index, entry_value, output ready);
endinterface

FILE: rtl/wto_out_if.sv
// Output channel of the wavetable oscillator: one sample per word.
interface wto_out_if #(
  parameter int SMP_W = 16
);
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

FILE: rtl/wto_table.sv
// Wave table storage: one write port, one registered read port.
module wto_table #(
  parameter int DEPTH = wto_pkg::DEF_TABLE_DEPTH,
  parameter int SMP_W = wto_pkg::DEF_SAMPLE_BITS,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic signed [SMP_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic signed [SMP_W-1:0] rdata_o
);

  logic signed [SMP_W-1:0] mem [DEPTH];
  logic signed [SMP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wavetable_oscillator_unit.sv
// Wavetable oscillator top level with linear interpolation.
//
// Usage:
//   in_i carries words with a mode field. A load word writes entry_value to
//   entry_index of the table and gives no output. A phase-clear word zeroes
//   the phase. A tick word makes one interpolated sample on out_o and steps
//   the phase. Configuration (phase increment, table length) is written by
//   the user through cfg_we_i / cfg_idx_i / cfg_data_i only while the block
//   is idle; the block itself does not enforce this.
// Steps:
//   A tick holds in_i.ready low from acceptance until its sample is in the
//   output register: MUL1 (one multiply for the table position), RDA and
//   RDB (two reads through the single table read port), MUL2 (one multiply
//   for the interpolation step) and FIN (add and fill the output register).
//   With table length 0 a tick goes straight to FIN, the sample is 0 and
//   the phase holds.
// Reset:
//   Phase, increment and length clear; table contents stay undefined until
//   loaded. If out_o stalls, the finished sample waits in the final step
//   and the next word is not taken until the output register frees up.
module wavetable_oscillator_unit #(
  parameter int TABLE_DEPTH = wto_pkg::DEF_TABLE_DEPTH,
  parameter int SAMPLE_BITS = wto_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wto_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wto_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wto_in_if.sink                         in_i,
  wto_out_if.source                      out_o
);

  import wto_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int LEN_W  = ($clog2(TABLE_DEPTH + 1) > LEN_MIN_W) ?
                          $clog2(TABLE_DEPTH + 1) : LEN_MIN_W;
  localparam int SMP_W  = SAMPLE_BITS;
  localparam int STEP_W = SMP_W + 1;
  // shared multiplier: operand A holds the unsigned phase or the signed
  // sample difference, operand B the length-1 or the fraction
  localparam int MA_W   = (SMP_W + 1 > PHASE_W + 1) ? SMP_W + 1 : PHASE_W + 1;
  localparam int MB_W   = ((IDX_W > FRAC_W) ? IDX_W : FRAC_W) + 1;
  localparam int MP_W   = MA_W + MB_W;
  localparam logic signed [MP_W-1:0] RND_HALF = MP_W'(1) << (FRAC_W - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_RDA  = 3'd2;
  localparam logic [2:0] ST_RDB  = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [PHASE_W-1:0]      phase_q, phase_d;
  logic [PHASE_W-1:0]      inc_q;
  logic [LEN_W-1:0]        len_q;
  logic [IDX_W-1:0]        i1_q, i1_d;
  logic [IDX_W-1:0]        i2_q, i2_d;
  logic [FRAC_W-1:0]       frac_q, frac_d;
  logic signed [SMP_W-1:0] w1_q, w1_d;
  logic signed [STEP_W-1:0] step_q, step_d;
  logic                    ovalid_q, ovalid_d;
  logic signed [SMP_W-1:0] sample_q, sample_d;

  logic                    in_fire;
  logic                    idx_ok;
  logic [LEN_W-1:0]        neff;
  logic [IDX_W-1:0]        nm1;
  logic                    tab_we;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [SMP_W-1:0] rd_data;
  logic signed [SMP_W:0]   diff;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  mul_p;
  logic signed [MP_W-1:0]  mul_r;
  logic signed [STEP_W-1:0] res;

  // effective length saturates at the table depth
  assign neff = (len_q > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_q;
  assign nm1  = IDX_W'(neff - LEN_W'(1));

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign idx_ok     = (32'(in_i.entry_index) < 32'(TABLE_DEPTH));
  assign tab_we     = in_fire && (in_i.mode == MODE_LOAD) && idx_ok;

  // single read port: i1 in the first read step, i2 in the second
  assign rd_addr = (state_q == ST_RDB) ? i2_q : i1_q;

  wto_table #(
    .DEPTH (TABLE_DEPTH),
    .SMP_W (SMP_W),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (in_i.entry_index),
    .wdata_i (in_i.entry_value),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // rd_data holds w2 during MUL2, w1 sits in w1_q
  assign diff = $signed({rd_data[SMP_W-1], rd_data}) - $signed({w1_q[SMP_W-1], w1_q});

  always_comb begin
    if (state_q == ST_MUL2) begin
      mul_a = MA_W'(diff);
      mul_b = MB_W'($signed({1'b0, frac_q}));
    end else begin
      mul_a = MA_W'($signed({1'b0, phase_q}));
      mul_b = MB_W'($signed({1'b0, nm1}));
    end
  end

  assign mul_p = mul_a * mul_b;
  assign mul_r = mul_p + RND_HALF;
  assign res   = $signed({w1_q[SMP_W-1], w1_q}) + step_q;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    i1_d     = i1_q;
    i2_d     = i2_q;
    frac_d   = frac_q;
    w1_d     = w1_q;
    step_d   = step_q;
    ovalid_d = ovalid_q;
    sample_d = sample_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.mode)
            MODE_TICK: begin
              if (neff == '0) begin
                // empty table: silent sample, phase holds
                w1_d    = '0;
                step_d  = '0;
                state_d = ST_FIN;
              end else begin
                state_d = ST_MUL1;
              end
            end
            MODE_PHASE_CLR: phase_d = '0;
            default: ;
          endcase
        end
      end
      ST_MUL1: begin
        i1_d    = mul_p[PHASE_W +: IDX_W];
        frac_d  = mul_p[PHASE_W-FRAC_W +: FRAC_W];
        phase_d = phase_q + inc_q;
        state_d = ST_RDA;
      end
      ST_RDA: begin
        // next entry, wrapping to 0 past the last one in use
        if ((LEN_W'(i1_q) + LEN_W'(1)) >= neff) begin
          i2_d = '0;
        end else begin
          i2_d = i1_q + IDX_W'(1);
        end
        state_d = ST_RDB;
      end
      ST_RDB: begin
        w1_d    = rd_data;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        // round to nearest, ties up: floor((d*f + half) / 2^16)
        step_d  = STEP_W'(mul_r >>> FRAC_W);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ovalid_q || out_o.ready) begin
          sample_d = res[SMP_W-1:0];
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= '0;
      inc_q    <= '0;
      len_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PHASE_INC: inc_q <= cfg_data_i[PHASE_W-1:0];
          CFG_TABLE_LEN: len_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q     <= i1_d;
    i2_q     <= i2_d;
    frac_q   <= frac_d;
    w1_q     <= w1_d;
    step_q   <= step_d;
    sample_q <= sample_d;
  end

  assign out_o.valid  = ovalid_q;
  assign out_o.sample = sample_q;

endmodule
